### rtl/core/depth_stencil_test_unit_defines.svh
// ----------------------------------------------------------------------------
// depth stencil test unit assertion macros
// concurrent property checks, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DEPTH_STENCIL_TEST_UNIT_DEFINES_SVH
`define DEPTH_STENCIL_TEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("depth stencil unit: same-cycle check failed");

// next-cycle implication
`define DST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("depth stencil unit: next-cycle check failed");

`else

`define DST_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DST_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// types, codes and compare / stencil operation functions of the depth
// stencil test unit
// ----------------------------------------------------------------------------
`default_nettype none

package dst_pkg;

   localparam int LOCATIONS   = 16384;
   localparam int LOC_W       = 14;
   localparam int DEPTH_W     = 24;
   localparam int STENCIL_W   = 8;
   localparam int ACTION_W    = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SETUP_W     = 12;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

   // item kinds
   localparam logic [ACTION_W-1:0] ACT_TEST        = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLR_DEPTH   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLR_STENCIL = 2'd2;

   // compare functions
   localparam logic [2:0] FN_NEVER         = 3'd0;
   localparam logic [2:0] FN_LESS          = 3'd1;
   localparam logic [2:0] FN_EQUAL         = 3'd2;
   localparam logic [2:0] FN_LESS_EQUAL    = 3'd3;
   localparam logic [2:0] FN_GREATER       = 3'd4;
   localparam logic [2:0] FN_NOT_EQUAL     = 3'd5;
   localparam logic [2:0] FN_GREATER_EQUAL = 3'd6;
   localparam logic [2:0] FN_ALWAYS        = 3'd7;

   // stencil operations
   localparam logic [2:0] OP_KEEP      = 3'd0;
   localparam logic [2:0] OP_ZERO      = 3'd1;
   localparam logic [2:0] OP_REPLACE   = 3'd2;
   localparam logic [2:0] OP_INCR_SAT  = 3'd3;
   localparam logic [2:0] OP_DECR_SAT  = 3'd4;
   localparam logic [2:0] OP_INVERT    = 3'd5;
   localparam logic [2:0] OP_INCR_WRAP = 3'd6;
   localparam logic [2:0] OP_DECR_WRAP = 3'd7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_Z_TEST_ON          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Z_FUNC             = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_WRITE_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_S_TEST_ON          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STENCIL_MASKS      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_S_REF              = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FRONT_SETUP        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_SETUP         = 3'd7;

   localparam logic [STENCIL_W-1:0] STENCIL_MAX = 8'hFF;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } dst_state_type;

   typedef struct packed {
      logic                  z_test_on;
      logic [2:0]            z_func;
      logic                  depth_write_enable;
      logic                  s_test_on;
      logic [CSR_DATA_W-1:0] stencil_masks;
      logic [STENCIL_W-1:0]  s_ref;
      logic [SETUP_W-1:0]    front_setup;
      logic [SETUP_W-1:0]    back_setup;
   } dst_cfg_type;

   localparam dst_cfg_type CFG_RESET = '{
      z_test_on:          1'b0,
      z_func:             FN_LESS,
      depth_write_enable: 1'b1,
      s_test_on:          1'b0,
      stencil_masks:      16'hFFFF,
      s_ref:              8'h00,
      front_setup:        12'h007,
      back_setup:         12'h007
   };

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [LOC_W-1:0]     location;
      logic [DEPTH_W-1:0]   frag_depth;
      logic                 back_facing;
      logic [STENCIL_W-1:0] stencil_value;
   } dst_item_type;

   typedef struct packed {
      logic                 passed;
      logic                 z_pass;
      logic                 s_pass;
      logic [STENCIL_W-1:0] stored_stencil;
      logic [DEPTH_W-1:0]   stored_depth;
   } dst_result_type;

   typedef struct packed {
      logic                 rd_en;
      logic [LOC_W-1:0]     rd_addr;
      logic [LOC_W-1:0]     wr_addr;
      logic                 depth_we;
      logic                 stencil_we;
      logic [DEPTH_W-1:0]   depth_wdata;
      logic [STENCIL_W-1:0] stencil_wdata;
   } dst_mem_ctrl_type;

   function automatic logic dst_compare(input logic [2:0] fn,
                                        input logic [DEPTH_W-1:0] a,
                                        input logic [DEPTH_W-1:0] b);
      logic res;
      case (fn)
         FN_NEVER:         res = 1'b0;
         FN_LESS:          res = (a < b);
         FN_EQUAL:         res = (a == b);
         FN_LESS_EQUAL:    res = (a <= b);
         FN_GREATER:       res = (a > b);
         FN_NOT_EQUAL:     res = (a != b);
         FN_GREATER_EQUAL: res = (a >= b);
         FN_ALWAYS:        res = 1'b1;
         default:          res = 1'b1;
      endcase
      return res;
   endfunction

   function automatic logic [STENCIL_W-1:0] dst_stencil_op(
      input logic [2:0]           op,
      input logic [STENCIL_W-1:0] refv,
      input logic [STENCIL_W-1:0] cur);
      logic [STENCIL_W-1:0] res;
      case (op)
         OP_KEEP:      res = cur;
         OP_ZERO:      res = '0;
         OP_REPLACE:   res = refv;
         OP_INCR_SAT:  res = (cur == STENCIL_MAX) ? STENCIL_MAX : STENCIL_W'(cur + 8'd1);
         OP_DECR_SAT:  res = (cur == '0) ? '0 : STENCIL_W'(cur - 8'd1);
         OP_INVERT:    res = ~cur;
         OP_INCR_WRAP: res = STENCIL_W'(cur + 8'd1);
         OP_DECR_WRAP: res = STENCIL_W'(cur - 8'd1);
         default:      res = cur;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/core/depth_stencil_test_unit.sv
// ----------------------------------------------------------------------------
// depth_stencil_test_unit
// per-sample depth and stencil test with depth and stencil stores
//
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     tuser action, tdata fragment or clear
//  rsp      out        rsp_tvalid/tready     tdata test flags and stored values
//  csr      in         csr_we                csr_index, csr_wdata
//
//  per item: the transfer, taken in the idle state, issues the read of both stores,
//  and the exec state compares, writes back and loads the result register;
//  the store reads are registered, and the next transfer is taken only after the
//  write-back of the item in flight
//  reset clears the sequencer, the result valid and the configuration; store
//  contents are undefined until cleared by clear items
//  a result waiting in the result register does not block the next transfer;
//  the write-back waits while the result register is full and not taken
// ----------------------------------------------------------------------------
`default_nettype none

module depth_stencil_test_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // slave stream
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // location, frag_depth, back_facing, stencil_value, zero pad
   input  wire logic [dst_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action
   input  wire logic [dst_pkg::ACTION_W-1:0]    req_tuser,
   // master stream
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // passed, depth pass, stencil pass, stored_stencil, stored_depth, zero pad
   output      logic [dst_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [dst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dst_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import dst_pkg::*;

   localparam int RSP_USED_W = 3 + STENCIL_W + DEPTH_W;

   dst_cfg_type          cfg;
   dst_item_type         req_item;
   dst_result_type       rsp_result;
   dst_mem_ctrl_type     mem_ctrl;
   logic [DEPTH_W-1:0]   depth_rd_data;
   logic [STENCIL_W-1:0] stencil_rd_data;

   always_comb begin
      req_item.action        = req_tuser;
      req_item.location      = req_tdata[LOC_W-1:0];
      req_item.frag_depth    = req_tdata[LOC_W+DEPTH_W-1:LOC_W];
      req_item.back_facing   = req_tdata[LOC_W+DEPTH_W];
      req_item.stencil_value = req_tdata[LOC_W+DEPTH_W+STENCIL_W:LOC_W+DEPTH_W+1];
   end

   assign rsp_tdata = {{(RSP_TDATA_W-RSP_USED_W){1'b0}},
                       rsp_result.stored_depth,
                       rsp_result.stored_stencil,
                       rsp_result.s_pass,
                       rsp_result.z_pass,
                       rsp_result.passed};

   dst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dst_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (LOCATIONS)
   ) u_depth_ram (
      .clock   (clock),
      .rd_en   (mem_ctrl.rd_en),
      .rd_addr (mem_ctrl.rd_addr),
      .rd_data (depth_rd_data),
      .wr_en   (mem_ctrl.depth_we),
      .wr_addr (mem_ctrl.wr_addr),
      .wr_data (mem_ctrl.depth_wdata)
   );

   dst_ram #(
      .WIDTH (STENCIL_W),
      .DEPTH (LOCATIONS)
   ) u_stencil_ram (
      .clock   (clock),
      .rd_en   (mem_ctrl.rd_en),
      .rd_addr (mem_ctrl.rd_addr),
      .rd_data (stencil_rd_data),
      .wr_en   (mem_ctrl.stencil_we),
      .wr_addr (mem_ctrl.wr_addr),
      .wr_data (mem_ctrl.stencil_wdata)
   );

   dst_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_item        (req_item),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_result      (rsp_result),
      .mem_ctrl        (mem_ctrl),
      .depth_rd_data   (depth_rd_data),
      .stencil_rd_data (stencil_rd_data)
   );

endmodule

`default_nettype wire

### rtl/core/dst_ram.sv
// ----------------------------------------------------------------------------
// dst_ram
// single-clock ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dst_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16384,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/dst_csr.sv
// ----------------------------------------------------------------------------
// dst_csr
// configuration registers of the depth stencil test unit
// ----------------------------------------------------------------------------
`default_nettype none

module dst_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [dst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dst_pkg::CSR_DATA_W-1:0] csr_wdata,
   output      dst_pkg::dst_cfg_type           cfg
);

   import dst_pkg::*;

   dst_cfg_type cfg_ff;
   dst_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_Z_TEST_ON:          cfg_in.z_test_on          = csr_wdata[0];
            REG_Z_FUNC:             cfg_in.z_func             = csr_wdata[2:0];
            REG_DEPTH_WRITE_ENABLE: cfg_in.depth_write_enable = csr_wdata[0];
            REG_S_TEST_ON:          cfg_in.s_test_on          = csr_wdata[0];
            REG_STENCIL_MASKS:      cfg_in.stencil_masks      = csr_wdata;
            REG_S_REF:              cfg_in.s_ref              = csr_wdata[STENCIL_W-1:0];
            REG_FRONT_SETUP:        cfg_in.front_setup        = csr_wdata[SETUP_W-1:0];
            REG_BACK_SETUP:         cfg_in.back_setup         = csr_wdata[SETUP_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/dst_core.sv
// ----------------------------------------------------------------------------
// dst_core
// item sequencer: issues the store read, runs the depth and stencil tests,
// writes back and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "depth_stencil_test_unit_defines.svh"

module dst_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dst_pkg::dst_cfg_type          cfg,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire dst_pkg::dst_item_type         req_item,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      dst_pkg::dst_result_type       rsp_result,
   output      dst_pkg::dst_mem_ctrl_type     mem_ctrl,
   input  wire logic [dst_pkg::DEPTH_W-1:0]   depth_rd_data,
   input  wire logic [dst_pkg::STENCIL_W-1:0] stencil_rd_data
);

   import dst_pkg::*;

   dst_state_type  state_ff;
   dst_state_type  state_in;
   dst_item_type   item_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   dst_result_type rsp_result_ff;

   logic           accept;
   logic           load;

   logic [STENCIL_W-1:0] rmask;
   logic [STENCIL_W-1:0] wmask;
   logic [SETUP_W-1:0]   setup;
   logic                 dp;
   logic                 sp;
   logic [2:0]           op;
   logic [STENCIL_W-1:0] op_val;
   logic [STENCIL_W-1:0] merged;
   logic                 depth_we;
   logic                 stencil_we;
   dst_result_type       result;

   // state transition
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      load       = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EXEC: load       = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            load       = 1'b0;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // test and update
   always_comb begin
      rmask  = cfg.stencil_masks[STENCIL_W-1:0];
      wmask  = cfg.stencil_masks[CSR_DATA_W-1:STENCIL_W];
      setup  = item_ff.back_facing ? cfg.back_setup : cfg.front_setup;
      dp     = cfg.z_test_on ?
               dst_compare(cfg.z_func, item_ff.frag_depth, depth_rd_data) : 1'b1;
      sp     = cfg.s_test_on ?
               dst_compare(setup[2:0],
                           {{(DEPTH_W-STENCIL_W){1'b0}}, cfg.s_ref & rmask},
                           {{(DEPTH_W-STENCIL_W){1'b0}}, stencil_rd_data & rmask}) : 1'b1;
      if (!sp) begin
         op = setup[5:3];
      end else if (!dp) begin
         op = setup[8:6];
      end else begin
         op = setup[11:9];
      end
      op_val = dst_stencil_op(op, cfg.s_ref, stencil_rd_data);
      merged = (stencil_rd_data & ~wmask) | (op_val & wmask);

      depth_we   = 1'b0;
      stencil_we = 1'b0;
      result     = '{passed: 1'b0, z_pass: 1'b0, s_pass: 1'b0,
                     stored_stencil: stencil_rd_data, stored_depth: depth_rd_data};
      case (item_ff.action)
         ACT_TEST: begin
            stencil_we    = cfg.s_test_on;
            depth_we      = dp && sp && cfg.depth_write_enable;
            result.passed = dp && sp;
            result.z_pass = dp;
            result.s_pass = sp;
            if (cfg.s_test_on) begin
               result.stored_stencil = merged;
            end
            if (depth_we) begin
               result.stored_depth = item_ff.frag_depth;
            end
         end
         ACT_CLR_DEPTH: begin
            depth_we            = 1'b1;
            result.stored_depth = item_ff.frag_depth;
         end
         ACT_CLR_STENCIL: begin
            stencil_we            = 1'b1;
            result.stored_stencil = item_ff.stencil_value;
         end
         default: begin
            depth_we   = 1'b0;
            stencil_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      mem_ctrl.rd_en         = accept;
      mem_ctrl.rd_addr       = req_item.location;
      mem_ctrl.wr_addr       = item_ff.location;
      mem_ctrl.depth_we      = load && depth_we;
      mem_ctrl.stencil_we    = load && stencil_we;
      mem_ctrl.depth_wdata   = result.stored_depth;
      mem_ctrl.stencil_wdata = result.stored_stencil;
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (load) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   `DST_ASSERT_NXT(a_accept_to_exec, clock, reset, accept, state_ff == ST_EXEC)
   `DST_ASSERT_IMP(a_no_write_when_held, clock, reset,
                   (state_ff == ST_EXEC) && rsp_valid_ff && !rsp_tready,
                   !mem_ctrl.depth_we && !mem_ctrl.stencil_we)
   `DST_ASSERT_IMP(a_passed_needs_both, clock, reset, rsp_valid_ff && rsp_result_ff.passed,
                   rsp_result_ff.z_pass && rsp_result_ff.s_pass)
   `DST_ASSERT_NXT(a_clear_flags_low, clock, reset, load && (item_ff.action != ACT_TEST),
                   !rsp_result_ff.passed && !rsp_result_ff.z_pass
                   && !rsp_result_ff.s_pass)

endmodule

`default_nettype wire

### test/tb_depth_stencil_test_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_stencil_test_unit
// Self-checking bench for the depth stencil test unit. Each sample transfer
// is run through a predictor that keeps its own copy of the depth and
// stencil stores, and each result transfer is checked field by field, in
// order. Configuration changes between batches only when the unit is idle.
// Both stream sides idle at random. One batch runs with no idling, and one
// batch holds the result side off long enough to stall the request side.
// ----------------------------------------------------------------------------

module tb_depth_stencil_test_unit;

   import dst_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 300;
   localparam int BATCHES     = 8;
   localparam int BATCH_ITEMS = 88;

   typedef struct packed {
      dst_result_type val;
      logic           depth_known;
      logic           stencil_known;
   } outcome_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [ACTION_W-1:0]    req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   dst_item_type   queued_samples [$];
   outcome_type    expected_outcomes [$];
   logic [LOC_W-1:0] ready_locations [$];

   logic [DEPTH_W-1:0]   depth_shadow    [LOCATIONS];
   logic [STENCIL_W-1:0] stencil_shadow  [LOCATIONS];
   bit                   depth_written   [LOCATIONS];
   bit                   stencil_written [LOCATIONS];
   dst_cfg_type          cfg_now = CFG_RESET;

   dst_item_type item_on_bus;
   bit           steady      = 1'b0;
   int           hold_order  = 0;
   int           hold_taken  = 0;
   int           hold_left   = 0;
   int           mismatches  = 0;
   int           cycle_count = 0;

   depth_stencil_test_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic meets_func(input logic [2:0] fn,
                                       input logic [DEPTH_W-1:0] a,
                                       input logic [DEPTH_W-1:0] b);
      case (fn)
         FN_NEVER:         return 1'b0;
         FN_LESS:          return a < b;
         FN_EQUAL:         return a == b;
         FN_LESS_EQUAL:    return a <= b;
         FN_GREATER:       return a > b;
         FN_NOT_EQUAL:     return a != b;
         FN_GREATER_EQUAL: return a >= b;
         default:          return 1'b1;
      endcase
   endfunction

   function automatic logic [STENCIL_W-1:0] next_stencil(input logic [2:0] op,
                                                         input logic [STENCIL_W-1:0] refv,
                                                         input logic [STENCIL_W-1:0] cur);
      case (op)
         OP_KEEP:      return cur;
         OP_ZERO:      return 8'h00;
         OP_REPLACE:   return refv;
         OP_INCR_SAT:  return (cur == 8'hFF) ? cur : cur + 8'd1;
         OP_DECR_SAT:  return (cur == 8'h00) ? cur : cur - 8'd1;
         OP_INVERT:    return ~cur;
         OP_INCR_WRAP: return cur + 8'd1;
         default:      return cur - 8'd1;
      endcase
   endfunction

   // updates the shadow stores and returns what the unit must report
   function automatic outcome_type run_sample_test(input dst_item_type it);
      outcome_type          o;
      logic [LOC_W-1:0]     loc;
      logic [DEPTH_W-1:0]   cur_d;
      logic [STENCIL_W-1:0] cur_s;
      logic [STENCIL_W-1:0] rmask;
      logic [STENCIL_W-1:0] wmask;
      logic [STENCIL_W-1:0] nv;
      logic [SETUP_W-1:0]   setup;
      logic [2:0]           op;
      logic                 dp;
      logic                 sp;
      o     = '0;
      loc   = it.location;
      cur_d = depth_shadow[loc];
      cur_s = stencil_shadow[loc];
      case (it.action)
         ACT_CLR_DEPTH: begin
            depth_shadow[loc]  = it.frag_depth;
            depth_written[loc] = 1'b1;
         end
         ACT_CLR_STENCIL: begin
            stencil_shadow[loc]  = it.stencil_value;
            stencil_written[loc] = 1'b1;
         end
         ACT_TEST: begin
            rmask = cfg_now.stencil_masks[7:0];
            wmask = cfg_now.stencil_masks[15:8];
            setup = it.back_facing ? cfg_now.back_setup : cfg_now.front_setup;
            dp = cfg_now.z_test_on ? meets_func(cfg_now.z_func, it.frag_depth, cur_d)
                                   : 1'b1;
            sp = 1'b1;
            if (cfg_now.s_test_on) begin
               sp = meets_func(setup[2:0], {16'h0, cfg_now.s_ref & rmask},
                               {16'h0, cur_s & rmask});
               if (!sp)
                  op = setup[5:3];
               else if (!dp)
                  op = setup[8:6];
               else
                  op = setup[11:9];
               nv = next_stencil(op, cfg_now.s_ref, cur_s);
               stencil_shadow[loc] = (cur_s & ~wmask) | (nv & wmask);
            end
            if (dp && sp && cfg_now.depth_write_enable)
               depth_shadow[loc] = it.frag_depth;
            o.val.passed = dp & sp;
            o.val.z_pass = dp;
            o.val.s_pass = sp;
         end
         default: ;
      endcase
      o.val.stored_stencil = stencil_shadow[loc];
      o.val.stored_depth   = depth_shadow[loc];
      o.stencil_known      = stencil_written[loc];
      o.depth_known        = depth_written[loc];
      return o;
   endfunction

   // request side
   always @(posedge clock) begin : sample_driver
      dst_item_type next_item;
      logic         offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(run_sample_test(item_on_bus));
         if (!req_tvalid || req_tready) begin
            offer = (queued_samples.size() != 0) && (steady || $urandom_range(99) >= 7);
            if (offer) begin
               next_item   = queued_samples.pop_front();
               item_on_bus = next_item;
               req_tdata   <= {1'b0, next_item.stencil_value, next_item.back_facing,
                               next_item.frag_depth, next_item.location};
               req_tuser   <= next_item.action;
            end
            req_tvalid <= offer;
         end
      end
   end

   task automatic flag_field(input string field, input logic [DEPTH_W-1:0] want,
                             input logic [DEPTH_W-1:0] seen);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, seen);
      mismatches++;
   endtask

   // result side
   always @(posedge clock) begin : result_monitor
      outcome_type            want;
      logic [RSP_TDATA_W-1:0] seen;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (expected_outcomes.size() == 0) begin
               $display("%0t: rsp transfer with nothing pending, expected none, got %h",
                        $time, seen);
               mismatches++;
            end else begin
               want = expected_outcomes.pop_front();
               if (seen[0] !== want.val.passed)
                  flag_field("passed", DEPTH_W'(want.val.passed), DEPTH_W'(seen[0]));
               if (seen[1] !== want.val.z_pass)
                  flag_field("depth pass", DEPTH_W'(want.val.z_pass), DEPTH_W'(seen[1]));
               if (seen[2] !== want.val.s_pass)
                  flag_field("stencil pass", DEPTH_W'(want.val.s_pass), DEPTH_W'(seen[2]));
               if (want.stencil_known && seen[10:3] !== want.val.stored_stencil)
                  flag_field("stored_stencil", DEPTH_W'(want.val.stored_stencil),
                             DEPTH_W'(seen[10:3]));
               if (want.depth_known && seen[34:11] !== want.val.stored_depth)
                  flag_field("stored_depth", want.val.stored_depth, seen[34:11]);
            end
         end
         if (hold_taken != hold_order) begin
            hold_taken <= hold_order;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 7);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [DEPTH_W-1:0] pick_depth();
      case ($urandom_range(7))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2:       return 24'h800000;
         3:       return 24'h7FFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [STENCIL_W-1:0] pick_stencil();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'h01;
         2:       return 8'h7F;
         3:       return 8'h80;
         4:       return 8'hFE;
         5:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // half the picks land on the first four opened locations for back-to-back hazards
   function automatic logic [LOC_W-1:0] pick_location();
      if ($urandom_range(1) == 0)
         return ready_locations[$urandom_range(3)];
      return ready_locations[$urandom_range(ready_locations.size() - 1)];
   endfunction

   function automatic logic [SETUP_W-1:0] setup_word(input logic [2:0] fn, input logic [2:0] fail_op,
                                                    input logic [2:0] zfail_op,
                                                    input logic [2:0] pass_op);
      return {pass_op, zfail_op, fail_op, fn};
   endfunction

   function automatic dst_cfg_type random_config();
      dst_cfg_type c;
      c.z_test_on          = ($urandom_range(99) < 80);
      c.z_func             = 3'($urandom_range(7));
      c.depth_write_enable = ($urandom_range(99) < 70);
      c.s_test_on          = ($urandom_range(99) < 80);
      case ($urandom_range(5))
         0:       c.stencil_masks = 16'hFFFF;
         1:       c.stencil_masks = 16'h0000;
         2:       c.stencil_masks = 16'h00FF;
         3:       c.stencil_masks = 16'hFF00;
         default: c.stencil_masks = 16'($urandom);
      endcase
      c.s_ref       = pick_stencil();
      c.front_setup = 12'($urandom);
      c.back_setup  = 12'($urandom);
      return c;
   endfunction

   task automatic queue_item(input logic [ACTION_W-1:0] action, input logic [LOC_W-1:0] loc,
                             input logic [DEPTH_W-1:0] depth, input logic back,
                             input logic [STENCIL_W-1:0] sval);
      dst_item_type it;
      it.action        = action;
      it.location      = loc;
      it.frag_depth    = depth;
      it.back_facing   = back;
      it.stencil_value = sval;
      queued_samples.push_back(it);
   endtask

   // clears both stores of a location before anything tests it
   task automatic open_location(input logic [LOC_W-1:0] loc, input logic [STENCIL_W-1:0] sval,
                                input logic [DEPTH_W-1:0] dval, input logic stencil_first);
      if (stencil_first) begin
         queue_item(ACT_CLR_STENCIL, loc, pick_depth(), 1'b1, sval);
         queue_item(ACT_CLR_DEPTH, loc, dval, 1'b0, pick_stencil());
      end else begin
         queue_item(ACT_CLR_DEPTH, loc, dval, 1'b0, pick_stencil());
         queue_item(ACT_CLR_STENCIL, loc, pick_depth(), 1'b1, sval);
      end
      ready_locations.push_back(loc);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic write_config(input dst_cfg_type c);
      put_reg(REG_Z_TEST_ON, {15'h0, c.z_test_on});
      put_reg(REG_Z_FUNC, {13'h0, c.z_func});
      put_reg(REG_DEPTH_WRITE_ENABLE, {15'h0, c.depth_write_enable});
      put_reg(REG_S_TEST_ON, {15'h0, c.s_test_on});
      put_reg(REG_STENCIL_MASKS, c.stencil_masks);
      put_reg(REG_S_REF, {8'h0, c.s_ref});
      put_reg(REG_FRONT_SETUP, {4'h0, c.front_setup});
      put_reg(REG_BACK_SETUP, {4'h0, c.back_setup});
      @(posedge clock);
      csr_we  <= 1'b0;
      cfg_now = c;
      @(negedge clock);
   endtask

   task automatic wait_drained(input int tail);
      do
         @(posedge clock);
      while (queued_samples.size() != 0 || req_tvalid || expected_outcomes.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic random_batch(input int count);
      int               n;
      int               r;
      logic [LOC_W-1:0] loc;
      n = 0;
      while (n < count) begin
         r   = $urandom_range(99);
         loc = pick_location();
         if (r < 70)
            queue_item(ACT_TEST, loc, pick_depth(), 1'($urandom), pick_stencil());
         else if (r < 80)
            queue_item(ACT_CLR_DEPTH, loc, pick_depth(), 1'($urandom), pick_stencil());
         else if (r < 90)
            queue_item(ACT_CLR_STENCIL, loc, pick_depth(), 1'($urandom), pick_stencil());
         else if (r < 93)
            queue_item(ACT_UNUSED, loc, pick_depth(), 1'($urandom), pick_stencil());
         else begin
            open_location(14'($urandom), pick_stencil(), pick_depth(), 1'($urandom));
            n++;
         end
         n++;
      end
   endtask

   initial begin
      dst_cfg_type c;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: both tests off, depth writes on
      open_location(14'h0000, 8'h00, 24'h000000, 1'b1);
      open_location(14'h3FFF, 8'hFF, 24'hFFFFFF, 1'b1);
      open_location(14'h2AAA, 8'h55, 24'hAAAAAA, 1'b0);
      open_location(14'h1555, 8'hAA, 24'h555555, 1'b1);
      queue_item(ACT_UNUSED, 14'h3FFF, 24'hFFFFFF, 1'b1, 8'hFF);
      queue_item(ACT_TEST, 14'h2AAA, 24'h123456, 1'b0, 8'h00);

      // saturating and wrapping ops at the stencil limits
      wait_drained(4);
      c                    = CFG_RESET;
      c.z_test_on          = 1'b1;
      c.z_func             = FN_LESS;
      c.depth_write_enable = 1'b1;
      c.s_test_on          = 1'b1;
      c.stencil_masks      = 16'hFFFF;
      c.s_ref              = 8'hFF;
      c.front_setup        = setup_word(FN_ALWAYS, OP_ZERO, OP_DECR_SAT, OP_INCR_SAT);
      c.back_setup         = setup_word(FN_NEVER, OP_DECR_WRAP, OP_INCR_WRAP, OP_INVERT);
      write_config(c);
      queue_item(ACT_CLR_STENCIL, 14'h0000, 24'h000000, 1'b0, 8'hFF);
      queue_item(ACT_CLR_DEPTH, 14'h0000, 24'h800000, 1'b0, 8'h00);
      queue_item(ACT_TEST, 14'h0000, 24'h000000, 1'b0, 8'h00);
      queue_item(ACT_TEST, 14'h0000, 24'hFFFFFF, 1'b0, 8'h00);
      queue_item(ACT_CLR_STENCIL, 14'h0000, 24'h000000, 1'b0, 8'h00);
      queue_item(ACT_TEST, 14'h0000, 24'hFFFFFF, 1'b0, 8'h00);
      queue_item(ACT_TEST, 14'h0000, 24'h000000, 1'b1, 8'h00);
      queue_item(ACT_TEST, 14'h0000, 24'h000000, 1'b1, 8'h00);

      // remaining ops, depth writes off
      wait_drained(4);
      c.z_func             = FN_GREATER_EQUAL;
      c.depth_write_enable = 1'b0;
      c.s_ref              = 8'h55;
      c.front_setup        = setup_word(FN_EQUAL, OP_INVERT, OP_KEEP, OP_REPLACE);
      c.back_setup         = setup_word(FN_GREATER, OP_INCR_SAT, OP_ZERO, OP_INCR_WRAP);
      write_config(c);
      queue_item(ACT_TEST, 14'h2AAA, 24'hFFFFFF, 1'b0, 8'h00);
      queue_item(ACT_TEST, 14'h3FFF, 24'hFFFFFF, 1'b0, 8'h00);
      queue_item(ACT_TEST, 14'h1555, 24'hFFFFFF, 1'b1, 8'h00);
      queue_item(ACT_TEST, 14'h3FFF, 24'h000000, 1'b1, 8'h00);
      queue_item(ACT_TEST, 14'h3FFF, 24'hFFFFFF, 1'b1, 8'h00);

      for (int p = 0; p < BATCHES; p++) begin
         case (p)
            2:       c = '0;
            3:       c = '1;
            default: c = random_config();
         endcase
         wait_drained(4);
         write_config(c);
         steady = (p == 0);
         random_batch(BATCH_ITEMS);
         if (p == 1)
            hold_order++;
      end

      wait_drained(10);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
